[rtl/core/vnr_pkg.sv]
// Shared types, codes and character helpers for the variable name resolver.
// No dependencies.
package vnr_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 256;

   localparam logic [1:0] CMD_VAR  = 2'd0;
   localparam logic [1:0] CMD_FUNC = 2'd1;
   localparam logic [1:0] CMD_NEXT = 2'd2;

   localparam logic [1:0] KIND_NUM = 2'd0;
   localparam logic [1:0] KIND_STR = 2'd1;
   localparam logic [1:0] KIND_INT = 2'd2;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] TYPE_BIT   = 8'h80;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_CREATED  = 3'd1,
      ST_UNKNOWN  = 3'd2,
      ST_ARRAY    = 3'd3,
      ST_SYNTAX   = 3'd4,
      ST_MISMATCH = 3'd5,
      ST_NOMEM    = 3'd6
   } status_type;

   typedef struct packed {
      logic        start;
      logic [15:0] key;
      logic        make;
   } tbl_req_type;

   typedef struct packed {
      logic       done;
      status_type status;
      logic [7:0] slot;
   } tbl_rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41 : 8'h5A]};
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h41 : 8'h5A], [8'h30 : 8'h39]};
   endfunction

endpackage

[rtl/core/vnr_table.sv]
// Name table: single-port synchronous memory with a linear search engine.
// Depends on vnr_pkg.
module vnr_table #(
   parameter int MaxEntries = vnr_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vnr_pkg::tbl_req_type  req,
   output vnr_pkg::tbl_rsp_type  rsp,
   output logic                  busy
);
   import vnr_pkg::*;

   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CntW = $clog2(MaxEntries + 1);

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type        state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  issue_ff, issue_in;
   logic [IdxW-1:0]  pend_idx_ff, pend_idx_in;
   logic             pend_ff, pend_in;
   logic [15:0]      key_ff, key_in;
   logic             make_ff, make_in;
   logic [15:0]      rd_data_ff;
   logic             rd_en;
   logic             wr_en;
   logic [15:0]      mem [MaxEntries];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      make_in     = make_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      rsp.done    = 1'b0;
      rsp.status  = ST_FOUND;
      rsp.slot    = 8'd0;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               key_in   = req.key;
               make_in  = req.make;
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en = issue_ff < count_ff;
            if (rd_en) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IdxW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && rd_data_ff == key_ff) begin
               rsp.done   = 1'b1;
               rsp.status = ST_FOUND;
               rsp.slot   = 8'(pend_idx_ff);
               state_in   = S_IDLE;
            end else if (!pend_ff && !rd_en) begin
               rsp.done = 1'b1;
               state_in = S_IDLE;
               if (!make_ff) begin
                  rsp.status = ST_UNKNOWN;
               end else if (count_ff == CntW'(MaxEntries)) begin
                  rsp.status = ST_NOMEM;
               end else begin
                  wr_en      = 1'b1;
                  count_in   = count_ff + 1'b1;
                  rsp.status = ST_CREATED;
                  rsp.slot   = 8'(count_ff[IdxW-1:0]);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == S_SCAN);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IdxW-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[IdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         issue_ff    <= '0;
         pend_ff     <= 1'b0;
         pend_idx_ff <= '0;
         key_ff      <= '0;
         make_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         issue_ff    <= issue_in;
         pend_ff     <= pend_in;
         pend_idx_ff <= pend_idx_in;
         key_ff      <= key_in;
         make_ff     <= make_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxEntries))
      else $error("entry count above table depth");

   a_create_bumps: assert property (@(posedge clock) disable iff (reset)
      rsp.done && rsp.status == ST_CREATED |=> count_ff == $past(count_ff) + 1'b1)
      else $error("create did not advance entry count");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == S_IDLE)
      else $error("search started while scanning");

endmodule

[rtl/core/variable_name_resolver.sv]
// Variable name resolver top level: folds name characters into a key, resolves it.
// Errors and array results are registered and appear in the cycle after their
// character. A terminator that searches starts a table scan reading one entry at
// a time. One word in flight at a time; req_stall is high while a search runs.
// Synchronous active-high reset empties the table and returns to idle.
// Depends on vnr_pkg and vnr_table.
module variable_name_resolver #(
   parameter int MaxEntries = vnr_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_ch,
   input  logic       req_create,
   input  logic       req_no_subscript,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_slot,
   output logic [7:0] rsp_key_high,
   output logic [7:0] rsp_key_low,
   output logic [1:0] rsp_value_kind
);
   import vnr_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_SUFFIX, PH_SEARCH} phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [1:0]  kind_ff, kind_in;
   logic        func_ff, func_in;
   logic        create_ff, create_in;
   logic        forbid_ff, forbid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_slot_ff, rsp_slot_in;
   logic [7:0]  rsp_key_high_ff, rsp_key_high_in;
   logic [7:0]  rsp_key_low_ff, rsp_key_low_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;

   logic        accept;
   logic        term;
   logic        emit;
   status_type  emit_status;
   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;
   logic        tbl_busy;

   assign req_stall = (phase_ff == PH_SEARCH) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in        = phase_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      kind_in         = kind_ff;
      func_in         = func_ff;
      create_in       = create_ff;
      forbid_in       = forbid_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_key_high_in = rsp_key_high_ff;
      rsp_key_low_in  = rsp_key_low_ff;
      rsp_kind_in     = rsp_kind_ff;
      term            = 1'b0;
      emit            = 1'b0;
      emit_status     = ST_FOUND;
      tbl_req.start   = 1'b0;
      tbl_req.make    = 1'b0;
      tbl_req.key     = {first_ff, second_ff};

      if (accept) begin
         case (req_command)
            CMD_VAR, CMD_FUNC: begin
               func_in   = (req_command == CMD_FUNC);
               create_in = req_create;
               forbid_in = (req_command == CMD_FUNC) || req_no_subscript;
               kind_in   = KIND_NUM;
               second_in = 8'd0;
               if (!is_letter(req_ch)) begin
                  first_in    = 8'd0;
                  emit        = 1'b1;
                  emit_status = ST_SYNTAX;
               end else begin
                  first_in = (req_command == CMD_FUNC) ? (req_ch | TYPE_BIT) : req_ch;
                  phase_in = PH_NAME;
               end
            end
            CMD_NEXT: begin
               if (phase_ff == PH_SUFFIX) begin
                  term = 1'b1;
               end else if (phase_ff == PH_NAME) begin
                  if (is_alnum(req_ch)) begin
                     if (second_ff == 8'd0) begin
                        second_in = req_ch;
                     end
                  end else if (!func_ff && req_ch == CH_DOLLAR) begin
                     kind_in   = KIND_STR;
                     second_in = second_ff | TYPE_BIT;
                     phase_in  = PH_SUFFIX;
                  end else if (!func_ff && req_ch == CH_PERCENT) begin
                     if (forbid_ff) begin
                        emit        = 1'b1;
                        emit_status = ST_SYNTAX;
                     end else begin
                        kind_in   = KIND_INT;
                        first_in  = first_ff | TYPE_BIT;
                        second_in = second_ff | TYPE_BIT;
                        phase_in  = PH_SUFFIX;
                     end
                  end else begin
                     term = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (term) begin
         if (func_ff) begin
            if (req_ch == CH_DOLLAR) begin
               emit        = 1'b1;
               emit_status = ST_MISMATCH;
            end else begin
               tbl_req.start = 1'b1;
               tbl_req.make  = 1'b1;
            end
         end else if (req_ch == CH_LPAREN && !forbid_ff) begin
            emit        = 1'b1;
            emit_status = ST_ARRAY;
         end else begin
            tbl_req.start = 1'b1;
            tbl_req.make  = create_ff;
         end
      end

      if (tbl_req.start) begin
         phase_in = PH_SEARCH;
      end

      if (emit) begin
         phase_in        = PH_IDLE;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = emit_status;
         rsp_slot_in     = 8'd0;
         rsp_key_high_in = first_in;
         rsp_key_low_in  = second_in;
         rsp_kind_in     = kind_in;
      end

      if (tbl_rsp.done) begin
         phase_in        = PH_IDLE;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = tbl_rsp.status;
         rsp_slot_in     = tbl_rsp.slot;
         rsp_key_high_in = first_ff;
         rsp_key_low_in  = second_ff;
         rsp_kind_in     = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         first_ff        <= 8'd0;
         second_ff       <= 8'd0;
         kind_ff         <= KIND_NUM;
         func_ff         <= 1'b0;
         create_ff       <= 1'b0;
         forbid_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_status_ff   <= ST_FOUND;
         rsp_slot_ff     <= 8'd0;
         rsp_key_high_ff <= 8'd0;
         rsp_key_low_ff  <= 8'd0;
         rsp_kind_ff     <= KIND_NUM;
      end else begin
         phase_ff        <= phase_in;
         first_ff        <= first_in;
         second_ff       <= second_in;
         kind_ff         <= kind_in;
         func_ff         <= func_in;
         create_ff       <= create_in;
         forbid_ff       <= forbid_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_slot_ff     <= rsp_slot_in;
         rsp_key_high_ff <= rsp_key_high_in;
         rsp_key_low_ff  <= rsp_key_low_in;
         rsp_kind_ff     <= rsp_kind_in;
      end
   end

   vnr_table #(
      .MaxEntries(MaxEntries)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .req  (tbl_req),
      .rsp  (tbl_rsp),
      .busy (tbl_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_key_high   = rsp_key_high_ff;
   assign rsp_key_low    = rsp_key_low_ff;
   assign rsp_value_kind = rsp_kind_ff;

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      tbl_rsp.done |-> phase_ff == PH_SEARCH)
      else $error("table result outside a search");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEARCH |-> !rsp_valid_ff)
      else $error("output word pending during search");

   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      tbl_busy |-> phase_ff == PH_SEARCH)
      else $error("table busy while front end not searching");

endmodule
